>>> hw/rtl/assert_macros.svh
// Assertion shorthands, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/tcarg_pkg.sv
package tcarg_pkg;

  localparam int unsigned CELLS       = 51;
  localparam int unsigned WINDOW      = 21;
  localparam int unsigned CENTER      = CELLS / 2;
  localparam int unsigned SEED_W      = 31;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned RULE_W      = 54;
  localparam int unsigned SEED_DIGITS = 21;

  localparam logic [RULE_W-1:0] RULE_RESET = 54'd6796640948097636;

  // Seed conversion: three base-3 digits per stage, divide by 27 via reciprocal.
  // Exact for every 31-bit dividend: 27*RECIP27 - 2^36 = 26 < 2^5.
  localparam int unsigned DIG_PER_STG = 3;
  localparam int unsigned CONV_STAGES = (SEED_DIGITS + DIG_PER_STG - 1) / DIG_PER_STG;
  localparam int unsigned LAST_STG    = CONV_STAGES;
  localparam int unsigned RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP27 = 32'd2545165806;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned PROD_W      = SEED_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  // Window value: groups of three cells (5-bit values), then weights 27^g.
  localparam int unsigned NUM_GRP  = (WINDOW + 2) / 3;
  localparam int unsigned NUM_PSUM = (NUM_GRP + 1) / 2;

  typedef logic [1:0]              trit_t;
  typedef trit_t [CELLS-1:0]       ring_t;
  typedef trit_t [SEED_DIGITS-1:0] digits_t;
  typedef logic [4:0]              grp_t;
  typedef grp_t [NUM_GRP-1:0]      grps_t;
  typedef trit_t [2:0]             split_t;

  function automatic trit_t rule_lookup(logic [RULE_W-1:0] rule, trit_t l, trit_t s, trit_t r);
    logic [4:0] idx;
    trit_t      e;
    idx = 5'(l) * 5'd9 + 5'(s) * 5'd3 + 5'(r);
    e   = rule[{idx, 1'b0} +: 2];
    return (e == 2'd3) ? 2'd2 : e;
  endfunction

  function automatic ring_t ca_step(ring_t cur, logic [RULE_W-1:0] rule);
    ring_t nxt;
    for (int unsigned i = 0; i < CELLS; i++) begin
      nxt[i] = rule_lookup(rule, cur[(i + CELLS - 1) % CELLS], cur[i], cur[(i + 1) % CELLS]);
    end
    return nxt;
  endfunction

  function automatic ring_t seed_ring(digits_t dig);
    ring_t r;
    r = '0;
    r[CELLS-1] = 2'd1;
    for (int unsigned i = 0; i < SEED_DIGITS; i++) begin
      r[i] = dig[i];
    end
    return r;
  endfunction

  // 0..26 into three base-3 digits, least significant first.
  function automatic split_t split27(logic [4:0] rem);
    logic [4:0] t;
    split_t     d;
    t = rem;
    d = '0;
    if (t >= 5'd18) begin
      d[2] = 2'd2;
      t    = t - 5'd18;
    end else if (t >= 5'd9) begin
      d[2] = 2'd1;
      t    = t - 5'd9;
    end
    if (t >= 5'd6) begin
      d[1] = 2'd2;
      t    = t - 5'd6;
    end else if (t >= 5'd3) begin
      d[1] = 2'd1;
      t    = t - 5'd3;
    end
    d[0] = t[1:0];
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] pow27(int unsigned j);
    logic [WORD_W-1:0] acc;
    acc = 1;
    for (int unsigned i = 0; i < j; i++) begin
      acc = acc * WORD_W'(27);
    end
    return acc;
  endfunction

  // Digit position p = WINDOW-1-k of window cell k lands in group p/3 at weight 3^(p%3).
  function automatic grps_t window_groups(ring_t r);
    grps_t g;
    int unsigned k;
    g = '0;
    for (int unsigned p = 0; p < WINDOW; p++) begin
      k = WINDOW - 1 - p;
      unique case (p % 3)
        0:       g[p / 3] = g[p / 3] + 5'(r[(CENTER + k) % CELLS]);
        1:       g[p / 3] = g[p / 3] + 5'(r[(CENTER + k) % CELLS]) * 5'd3;
        default: g[p / 3] = g[p / 3] + 5'(r[(CENTER + k) % CELLS]) * 5'd9;
      endcase
    end
    return g;
  endfunction

endpackage

>>> hw/rtl/tcarg_if.sv
interface tcarg_in_if import tcarg_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [SEED_W-1:0] seed;

  modport source (output valid, output command, output seed, input ready);
  modport sink   (input valid, input command, input seed, output ready);
endinterface

interface tcarg_out_if import tcarg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

>>> hw/rtl/ternary_ca_random_generator.sv
// Ternary cellular-automaton random word generator.
// item_i (valid/ready): command 0 seeds the ring from seed and runs one warm-up
//   step (no word out); command 1 steps the ring once and yields one word.
// word_o (valid/ready): random_word, base-3 value of the 21 cells from the
//   ring center onward, first cell most significant, modulo 2^32.
// cfg_we_i/cfg_wdata_i: rule table write, 27 two-bit entries. Write only when
//   the pipe is empty; it takes effect on the next ring update.
// Throughput: one item per cycle. Pipe: input register, 7 seed-conversion
//   stages (one divide-by-27 reciprocal multiply each, 3 digits per stage),
//   ring update, group weighting, output register.
// Reset: ring all zero, rule table at its default, pipe empty, no word valid.
//   A step before any seed runs from the all-zero ring.
// Stall: the whole pipe freezes while a valid word is not taken; item_i.ready
//   follows (!word_o.valid || word_o.ready), so a new item enters in the same
//   cycle the waiting word leaves.
`include "assert_macros.svh"

module ternary_ca_random_generator import tcarg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RULE_W-1:0] cfg_wdata_i,
  tcarg_in_if.sink          item_i,
  tcarg_out_if.source       word_o
);

  logic adv;

  logic [RULE_W-1:0] rule_q;

  // Seed conversion pipe; stage 0 is the input register.
  logic [CONV_STAGES:0] vld_q;
  logic [CONV_STAGES:0] cmd_q;
  logic [SEED_W-1:0]    val_q [CONV_STAGES+1];
  digits_t              dig_q [CONV_STAGES+1];

  logic [SEED_W-1:0]    val_d  [1:CONV_STAGES];
  digits_t              dig_d  [1:CONV_STAGES];
  logic [PROD_W-1:0]    prod_c [1:CONV_STAGES];
  logic [QUOT_W-1:0]    quot_c [1:CONV_STAGES];
  logic [4:0]           rem_c  [1:CONV_STAGES];
  split_t               spl_c  [1:CONV_STAGES];

  ring_t ring_q;
  ring_t ring_d;

  logic  win_vld_q;
  grps_t grp_q;

  logic              psum_vld_q;
  logic [WORD_W-1:0] psum_q [NUM_PSUM];
  logic [WORD_W-1:0] psum_d [NUM_PSUM];

  logic              out_vld_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;

  // Global advance: everything moves unless a finished word is stuck.
  assign adv          = !out_vld_q || word_o.ready;
  assign item_i.ready = adv;

  assign word_o.valid       = out_vld_q;
  assign word_o.random_word = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= RULE_RESET;
    end else if (cfg_we_i) begin
      rule_q <= cfg_wdata_i;
    end
  end

  // Each stage peels three base-3 digits: q = v/27 by reciprocal, r = v - 27q.
  // Only the low 5 bits of 27q are needed since r < 27.
  always_comb begin
    for (int unsigned k = 1; k <= CONV_STAGES; k++) begin
      prod_c[k] = PROD_W'(val_q[k-1]) * PROD_W'(RECIP27);
      quot_c[k] = prod_c[k][PROD_W-1:RECIP_SHIFT];
      rem_c[k]  = val_q[k-1][4:0] - 5'(quot_c[k]) * 5'd27;
      spl_c[k]  = split27(rem_c[k]);
      val_d[k]  = SEED_W'(quot_c[k]);
      dig_d[k]  = dig_q[k-1];
      for (int unsigned m = 0; m < DIG_PER_STG; m++) begin
        if (DIG_PER_STG * (k - 1) + m < SEED_DIGITS) begin
          dig_d[k][DIG_PER_STG * (k - 1) + m] = spl_c[k][m];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[CONV_STAGES-1:0], item_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q    <= {cmd_q[CONV_STAGES-1:0], item_i.command};
      val_q[0] <= item_i.seed;
      dig_q[0] <= '0;
      for (int unsigned k = 1; k <= CONV_STAGES; k++) begin
        val_q[k] <= val_d[k];
        dig_q[k] <= dig_d[k];
      end
    end
  end

  // Ring update: a seed rebuilds the ring first, then one step either way.
  assign ring_d = ca_step(cmd_q[LAST_STG] ? ring_q : seed_ring(dig_q[LAST_STG]), rule_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q     <= '0;
      win_vld_q  <= 1'b0;
      psum_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (adv) begin
      if (vld_q[LAST_STG]) begin
        ring_q <= ring_d;
      end
      win_vld_q  <= vld_q[LAST_STG] && cmd_q[LAST_STG];
      psum_vld_q <= win_vld_q;
      out_vld_q  <= psum_vld_q;
    end
  end

  // Pairs of weighted groups, then the final sum; all modulo 2^32.
  always_comb begin
    for (int unsigned i = 0; i < NUM_PSUM; i++) begin
      psum_d[i] = WORD_W'(grp_q[2 * i]) * pow27(2 * i);
      if (2 * i + 1 < NUM_GRP) begin
        psum_d[i] = psum_d[i] + WORD_W'(grp_q[2 * i + 1]) * pow27(2 * i + 1);
      end
    end
    word_d = '0;
    for (int unsigned i = 0; i < NUM_PSUM; i++) begin
      word_d = word_d + psum_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grp_q  <= window_groups(ring_d);
      psum_q <= psum_d;
      word_q <= word_d;
    end
  end

  `ASSERT_RST(a_ring_moves_on_item, !(vld_q[LAST_STG] && adv) |=> $stable(ring_q), "ring changed without an item")
  `ASSERT_RST(a_seed_no_word, vld_q[LAST_STG] && !cmd_q[LAST_STG] && adv |=> !win_vld_q, "seed item made a word")
  `ASSERT_RST(a_word_from_pipe, $rose(out_vld_q) |-> $past(psum_vld_q), "word valid without a sum")
  `ASSERT_ANY(a_reset_empty, !rst_ni |=> !word_o.valid, "word valid right after reset")

endmodule

>>> sim/ternary_ca_random_generator_test.sv
module ternary_ca_random_generator_test import tcarg_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles (nothing accepted anywhere) before the run is declared hung.
  // The longest legal quiet stretch is the forced output hold-off below plus a
  // pipe's worth of latency, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Output hold-off used to back the pipe up into the input.
  localparam int unsigned HOLD_CYCLES    = 100;
  // Seed items leave no word, so wait this long before touching the rule table
  // or ending the run.
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned MAX_REPORTS    = 50;

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_STEP = 1'b1
  } ca_cmd_e;

  typedef struct {
    ca_cmd_e           cmd;
    logic [SEED_W-1:0] seed;
  } ca_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [RULE_W-1:0] cfg_wdata_i;

  tcarg_in_if  item_if ();
  tcarg_out_if word_if ();

  ternary_ca_random_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .word_o      (word_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the ring and of the rule table.
  // ---------------------------------------------------------------------------
  trit_t             ring_model [CELLS];
  logic [RULE_W-1:0] rule_model;

  ca_item_t          pending_items [$];   // waiting to be offered
  logic [WORD_W-1:0] expected_words [$];  // predicted, not yet seen

  int unsigned error_count;
  int unsigned seeds_taken;
  int unsigned steps_taken;
  int unsigned words_checked;
  int unsigned rule_writes;

  // Idling knobs, set per phase by the sequencer.
  bit          sender_idling;
  bit          receiver_idling;
  int unsigned holds_wanted;
  int unsigned holds_started;

  // Next state of one cell; entry 3 in the table reads as 2.
  function automatic trit_t next_trit(trit_t left, trit_t self, trit_t right);
    int unsigned k;
    trit_t       e;
    k = 9 * left + 3 * self + right;
    e = rule_model[2 * k +: 2];
    return (e == 2'd3) ? 2'd2 : e;
  endfunction

  // All cells move at once, neighbors wrap around the ring.
  task automatic advance_ring();
    trit_t nxt [CELLS];
    for (int unsigned i = 0; i < CELLS; i++) begin
      nxt[i] = next_trit(ring_model[(i + CELLS - 1) % CELLS], ring_model[i],
                         ring_model[(i + 1) % CELLS]);
    end
    ring_model = nxt;
  endtask

  // Clear, mark the last cell, lay the seed's base-3 digits LSD first.
  task automatic load_seed(logic [SEED_W-1:0] seed);
    longint unsigned rest;
    rest = 64'(seed);
    foreach (ring_model[i]) ring_model[i] = 2'd0;
    ring_model[CELLS-1] = 2'd1;
    for (int unsigned i = 0; i < SEED_DIGITS; i++) begin
      ring_model[i] = trit_t'(rest % 3);
      rest = rest / 3;
    end
  endtask

  // Base-3 value of the window, first cell most significant, wraps at 2^32.
  function automatic logic [WORD_W-1:0] window_word();
    logic [WORD_W-1:0] w;
    w = '0;
    for (int unsigned k = 0; k < WINDOW; k++) begin
      w = w * 3 + WORD_W'(ring_model[(CENTER + k) % CELLS]);
    end
    return w;
  endfunction

  // Called once per accepted item, in acceptance order.
  task automatic predict_item(ca_item_t it);
    if (it.cmd == CMD_SEED) begin
      load_seed(it.seed);
      advance_ring();
      seeds_taken++;
    end else begin
      advance_ring();
      expected_words.push_back(window_word());
      steps_taken++;
    end
  endtask

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    if (error_count < MAX_REPORTS) begin
      $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and initial values.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = RULE_RESET;
    item_if.valid   = 1'b0;
    item_if.command = CMD_SEED;
    item_if.seed    = '0;
    word_if.ready   = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the pending items, with random gaps when enabled.
  // ---------------------------------------------------------------------------
  int unsigned send_gap;

  always @(posedge clk_i) begin : drive
    ca_item_t nxt;
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        nxt.cmd  = ca_cmd_e'(item_if.command);
        nxt.seed = item_if.seed;
        predict_item(nxt);
        if (sender_idling && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(1, 14);
        end
      end
      // Slot is free when nothing is offered or the offer just went through.
      if (!item_if.valid || item_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          item_if.valid   <= 1'b1;
          item_if.command <= nxt.cmd;
          item_if.seed    <= nxt.seed;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks words in order, drives ready with stalls and hold-offs.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned stall_left;

  always @(posedge clk_i) begin : watch
    logic [WORD_W-1:0] want;
    if (!rst_ni) begin
      word_if.ready <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (word_if.valid && word_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected random_word", word_if.random_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (word_if.random_word !== want) begin
            report_mismatch("random_word", word_if.random_word, want);
          end
          words_checked++;
        end
      end
      // A requested hold-off is counted out here, independent of the sender.
      if (holds_started < holds_wanted) begin
        holds_started++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= 1'b1;
        if (receiver_idling && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 14);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: quiet cycles with no handshake and no rule write.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (item_if.valid && item_if.ready)
        || (word_if.valid && word_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("ternary_ca_random_generator_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------
  function automatic ca_item_t make_item(ca_cmd_e cmd, logic [SEED_W-1:0] seed);
    ca_item_t it;
    it.cmd  = cmd;
    it.seed = seed;
    return it;
  endfunction

  // Mostly steps; a seed now and then, sometimes an extreme one.
  function automatic ca_item_t random_item();
    int unsigned pick;
    logic [SEED_W-1:0] seed;
    pick = $urandom_range(0, 99);
    if (pick >= 12) return make_item(CMD_STEP, SEED_W'($urandom()));
    case ($urandom_range(0, 7))
      0:       seed = '0;
      1:       seed = '1;
      2:       seed = SEED_W'($urandom_range(0, 26));
      default: seed = SEED_W'($urandom());
    endcase
    return make_item(CMD_SEED, seed);
  endfunction

  // Pipe empty: nothing queued or offered, no word owed, seed items drained.
  // Checked again after settling, since the last pop can land on the same
  // edge as the first check.
  task automatic wait_idle();
    do begin
      while (pending_items.size() > 0 || item_if.valid || expected_words.size() > 0) begin
        @(posedge clk_i);
      end
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end while (pending_items.size() > 0 || item_if.valid || expected_words.size() > 0);
  endtask

  task automatic write_rule(logic [RULE_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rule_model = value;
    rule_writes++;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) pending_items.push_back(random_item());
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  initial begin
    foreach (ring_model[i]) ring_model[i] = 2'd0;
    rule_model      = RULE_RESET;
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
    holds_wanted    = 0;
    holds_started   = 0;
    error_count     = 0;
    seeds_taken     = 0;
    steps_taken     = 0;
    words_checked   = 0;
    rule_writes     = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: steps from the all-zero ring before any seed, then seed
    // extremes, digit patterns, and back-to-back seeds (second one wins).
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_STEP, '1));
    pending_items.push_back(make_item(CMD_SEED, '0));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, '1));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, SEED_W'(1)));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, SEED_W'(1162261466))); // 19 digits of 2
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, SEED_W'(1162261467))); // 3^19
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, SEED_W'(32'h5555_5555)));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, SEED_W'(32'h2AAA_AAAA)));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_SEED, '1));
    pending_items.push_back(make_item(CMD_SEED, SEED_W'(12345)));
    pending_items.push_back(make_item(CMD_STEP, '0));
    pending_items.push_back(make_item(CMD_STEP, '0));
    wait_idle();
    run_random(150);

    // Every entry 3, read as 2 throughout.
    write_rule({RULE_W{1'b1}});
    pending_items.push_back(make_item(CMD_STEP, '0));
    run_random(80);

    // All-zero table collapses the ring.
    write_rule('0);
    run_random(60);

    // Back-pressure: steady sender, receiver holds off long enough to fill the
    // pipe and stall the input.
    write_rule(RULE_W'({$urandom(), $urandom()}));
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    holds_wanted++;
    run_random(120);

    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
    write_rule(RULE_W'({$urandom(), $urandom()}));
    run_random(150);
    write_rule(RULE_W'({$urandom(), $urandom()}));
    run_random(120);

    // Last stretch at full rate on both sides, default table again.
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    write_rule(RULE_RESET);
    run_random(120);

    if (expected_words.size() != 0) begin
      report_mismatch("words never delivered", WORD_W'(expected_words.size()), '0);
    end

    $display("covered %0d seed items and %0d step items, %0d words compared",
             seeds_taken, steps_taken, words_checked);
    $display("across %0d rule table writes, with gaps, stalls and a full-pipe hold-off",
             rule_writes);
    if (error_count == 0) begin
      $display("ternary_ca_random_generator_test OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("ternary_ca_random_generator_test NOT OK");
    end
    $finish;
  end

endmodule
